/* sv/irig_pkg.sv */
// irig_pkg: shared types, constants and helper functions for the irig-b encoder
// no dependencies; used by irig_front, irig_queue, irig_back and the top level
package irig_pkg;

  localparam int NUM_SLOTS   = 61;
  localparam int SLOT_W      = 6;
  localparam int CHAR_CNT    = 15;
  localparam int POS_W       = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] FRAME_MARK = 8'd35;
  localparam logic [7:0] ASCII_ZERO = 8'd48;

  // request kinds on the input channel
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_TICKS_PER_SLOT = 2'd0;
  localparam logic [1:0] CFG_ZERO_WIDTH     = 2'd1;
  localparam logic [1:0] CFG_ONE_WIDTH      = 2'd2;
  localparam logic [1:0] CFG_MARKER_WIDTH   = 2'd3;

  localparam logic [7:0] RST_TICKS_PER_SLOT = 8'd10;
  localparam logic [7:0] RST_ZERO_WIDTH     = 8'd2;
  localparam logic [7:0] RST_ONE_WIDTH      = 8'd5;
  localparam logic [7:0] RST_MARKER_WIDTH   = 8'd8;

  // reference marker plus P0..P6
  localparam logic [NUM_SLOTS-1:0] MARK_MASK =
    (61'd1 << 0)  | (61'd1 << 1)  | (61'd1 << 10) | (61'd1 << 20) |
    (61'd1 << 30) | (61'd1 << 40) | (61'd1 << 50) | (61'd1 << 60);

  typedef struct packed {
    logic [7:0] ticks_per_slot;
    logic [7:0] zero_width;
    logic [7:0] one_width;
    logic [7:0] marker_width;
  } cfg_t;

  // time fields of one captured frame, day of year still binary
  typedef struct packed {
    logic [8:0] day;
    logic [3:0] sec_u;
    logic [2:0] sec_t;
    logic [3:0] min_u;
    logic [2:0] min_t;
    logic [3:0] hr_u;
    logic [1:0] hr_t;
    logic [3:0] yr_u;
    logic [3:0] yr_t;
  } frame_t;

  typedef struct packed {
    logic   is_frame;
    frame_t frame;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [3:0] nib(input logic [7:0] c);
    logic [7:0] d;
    d = c - ASCII_ZERO;
    return d[3:0];
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    unique case (month)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

/* sv/irig_if.sv */
// irig_in_if / irig_out_if: valid-ready channels of the irig-b encoder
// no dependencies
interface irig_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface irig_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic sending;
  logic frame_done;

  modport source (output valid, output line_level, output sending, output frame_done,
                  input ready);
  modport sink   (input valid, input line_level, input sending, input frame_done,
                  output ready);
endinterface

/* sv/irig_front.sv */
// irig_front: accepts requests, captures '#...#' frames and queues tick / frame commands
// depends on irig_pkg and irig_if
module irig_front (
  input  logic                clk,
  input  logic                rst_n,
  irig_in_if.sink             in_ch,
  input  irig_pkg::q_stat_t   q_stat,
  output logic                push,
  output irig_pkg::cmd_t      push_cmd
);

  logic [7:0]                  chars_r [irig_pkg::CHAR_CNT];
  logic [7:0]                  chars_nxt [irig_pkg::CHAR_CNT];
  logic                        active_r, active_nxt;
  logic [irig_pkg::POS_W-1:0]  pos_r, pos_nxt;

  logic       accept;
  logic       is_mark;
  logic [3:0] n2, n3, n4, n5, n6, n7;
  logic [7:0] month_raw;
  logic [3:0] month;
  logic [1:0] leap_sum;
  logic       leap;
  logic [8:0] day;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_mark     = (in_ch.rx_byte == irig_pkg::FRAME_MARK);

  // day of year from the captured date characters
  always_comb begin
    n2 = irig_pkg::nib(chars_r[2]);
    n3 = irig_pkg::nib(chars_r[3]);
    n4 = irig_pkg::nib(chars_r[4]);
    n5 = irig_pkg::nib(chars_r[5]);
    n6 = irig_pkg::nib(chars_r[6]);
    n7 = irig_pkg::nib(chars_r[7]);
    // 10*y3 + y4 mod 4 is 2*y3 + y4 mod 4
    leap_sum  = {n2[0], 1'b0} + n3[1:0];
    leap      = (leap_sum == 2'd0);
    month_raw = {1'b0, n4, 3'b000} + {3'b000, n4, 1'b0} + {4'd0, n5};
    month     = (month_raw > 8'd12) ? 4'd12 : month_raw[3:0];
    day       = irig_pkg::days_before(month)
              + {8'd0, (leap && (month >= 4'd3))}
              + {2'b00, n6, 3'b000} + {4'd0, n6, 1'b0} + {5'd0, n7};
  end

  always_comb begin
    push_cmd.is_frame    = 1'b0;
    push_cmd.frame.day   = day;
    push_cmd.frame.sec_u = irig_pkg::nib(chars_r[14]);
    push_cmd.frame.sec_t = 3'(irig_pkg::nib(chars_r[13]));
    push_cmd.frame.min_u = irig_pkg::nib(chars_r[12]);
    push_cmd.frame.min_t = 3'(irig_pkg::nib(chars_r[11]));
    push_cmd.frame.hr_u  = irig_pkg::nib(chars_r[10]);
    push_cmd.frame.hr_t  = 2'(irig_pkg::nib(chars_r[9]));
    push_cmd.frame.yr_u  = n3;
    push_cmd.frame.yr_t  = n2;
    push       = 1'b0;
    active_nxt = active_r;
    pos_nxt    = pos_r;
    chars_nxt  = chars_r;
    if (accept) begin
      if (in_ch.req_type == irig_pkg::REQ_TICK) begin
        push = 1'b1;
      end else if (is_mark) begin
        if (active_r) begin
          push              = 1'b1;
          push_cmd.is_frame = 1'b1;
          active_nxt        = 1'b0;
        end else begin
          active_nxt = 1'b1;
          pos_nxt    = '0;
        end
      end else if (active_r && (pos_r < irig_pkg::POS_W'(irig_pkg::CHAR_CNT))) begin
        chars_nxt[pos_r] = in_ch.rx_byte;
        pos_nxt          = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= '0;
      for (int i = 0; i < irig_pkg::CHAR_CNT; i++) begin
        chars_r[i] <= 8'd0;
      end
    end else begin
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
      chars_r  <= chars_nxt;
    end
  end

endmodule

/* sv/irig_queue.sv */
// irig_queue: short command queue between the capture front and the slot sequencer
// depends on irig_pkg
module irig_queue #(
  parameter int DEPTH = irig_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  irig_pkg::cmd_t     push_cmd,
  input  logic               pop,
  output irig_pkg::cmd_t     head,
  output irig_pkg::q_stat_t  q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  irig_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* sv/irig_back.sv */
// irig_back: slot sequencer; loads frames into the one-bit map and emits one result per tick
// depends on irig_pkg and irig_if
module irig_back (
  input  logic                clk,
  input  logic                rst_n,
  input  irig_pkg::cfg_t      cfg,
  input  irig_pkg::cmd_t      head,
  input  irig_pkg::q_stat_t   q_stat,
  output logic                pop,
  irig_out_if.source          out_ch
);

  logic [irig_pkg::NUM_SLOTS-1:0] ones_r, ones_nxt;
  logic                           xmit_r, xmit_nxt;
  logic [irig_pkg::SLOT_W-1:0]    slot_r, slot_nxt;
  logic [7:0]                     tick_r, tick_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           level_r, level_nxt;
  logic                           sending_r, sending_nxt;
  logic                           done_r, done_nxt;

  logic        can_emit;
  logic [8:0]  day;
  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [13:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  units_full;
  logic [7:0]  width;
  logic [8:0]  tick_inc;
  logic        slot_end;

  assign can_emit = !out_valid_r || out_ch.ready;
  assign pop      = !q_stat.empty && (head.is_frame || can_emit);

  // day of year into bcd: hundreds by compares, tens by reciprocal of ten
  // only the low two bits of the hundreds digit are sent
  always_comb begin
    day = head.frame.day;
    if (day >= 9'd500) begin
      hund = 2'd1;
      rem  = 7'(day - 9'd500);
    end else if (day >= 9'd400) begin
      hund = 2'd0;
      rem  = 7'(day - 9'd400);
    end else if (day >= 9'd300) begin
      hund = 2'd3;
      rem  = 7'(day - 9'd300);
    end else if (day >= 9'd200) begin
      hund = 2'd2;
      rem  = 7'(day - 9'd200);
    end else if (day >= 9'd100) begin
      hund = 2'd1;
      rem  = 7'(day - 9'd100);
    end else begin
      hund = 2'd0;
      rem  = day[6:0];
    end
    tens_prod  = {7'd0, rem} * 14'd103;
    tens       = tens_prod[13:10];
    units_full = rem - {tens[3:0], 3'b000} - {2'b00, tens, 1'b0};
  end

  always_comb begin
    ones_nxt        = '0;
    ones_nxt[5:2]   = head.frame.sec_u;
    ones_nxt[9:7]   = head.frame.sec_t;
    ones_nxt[14:11] = head.frame.min_u;
    ones_nxt[18:16] = head.frame.min_t;
    ones_nxt[24:21] = head.frame.hr_u;
    ones_nxt[27:26] = head.frame.hr_t;
    ones_nxt[34:31] = units_full[3:0];
    ones_nxt[39:36] = tens;
    ones_nxt[42:41] = hund;
    ones_nxt[54:51] = head.frame.yr_u;
    ones_nxt[59:56] = head.frame.yr_t;
  end

  always_comb begin
    if (irig_pkg::MARK_MASK[slot_r]) begin
      width = cfg.marker_width;
    end else if (ones_r[slot_r]) begin
      width = cfg.one_width;
    end else begin
      width = cfg.zero_width;
    end
    tick_inc = {1'b0, tick_r} + 9'd1;
    slot_end = (tick_inc >= {1'b0, cfg.ticks_per_slot});
  end

  always_comb begin
    xmit_nxt      = xmit_r;
    slot_nxt      = slot_r;
    tick_nxt      = tick_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    level_nxt     = level_r;
    sending_nxt   = sending_r;
    done_nxt      = done_r;
    if (pop) begin
      if (head.is_frame) begin
        xmit_nxt = 1'b1;
        slot_nxt = '0;
        tick_nxt = '0;
      end else begin
        out_valid_nxt = 1'b1;
        level_nxt     = 1'b0;
        sending_nxt   = 1'b0;
        done_nxt      = 1'b0;
        if (xmit_r) begin
          level_nxt   = (width > tick_r);
          sending_nxt = 1'b1;
          if (slot_end) begin
            tick_nxt = '0;
            if (slot_r >= irig_pkg::SLOT_W'(irig_pkg::NUM_SLOTS - 1)) begin
              done_nxt = 1'b1;
              xmit_nxt = 1'b0;
              slot_nxt = '0;
            end else begin
              slot_nxt = slot_r + 1'b1;
            end
          end else begin
            tick_nxt = tick_inc[7:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.is_frame) begin
      ones_r <= ones_nxt;
    end
    level_r   <= level_nxt;
    sending_r <= sending_nxt;
    done_r    <= done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xmit_r      <= 1'b0;
      slot_r      <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      xmit_r      <= xmit_nxt;
      slot_r      <= slot_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.line_level = level_r;
  assign out_ch.sending    = sending_r;
  assign out_ch.frame_done = done_r;

endmodule

/* sv/irig_b_time_code_encoder_top.sv */
// irig_b_time_code_encoder_top: irig-b time code encoder, top level with config registers
// depends on irig_pkg, irig_if, irig_front, irig_queue and irig_back
//
// Usage:
//   in_ch carries requests: req_type 0 is a received ascii byte (rx_byte), req_type 1
//   is a millisecond tick. Bytes between two '#' form a frame 'YYYYMMDD?hhmmss'; the
//   closing '#' starts a 61-slot irig-b frame from slot 0, tick 0.
//   out_ch carries one result per tick request (line_level, sending, frame_done) and
//   nothing for byte requests; with no frame running all three fields are 0.
//   cfg_we/cfg_idx/cfg_wdata write ticks_per_slot, zero_width, one_width and
//   marker_width; write them only while the block is idle.
// Timing:
//   one request is taken every cycle while the command queue is not full. A tick is
//   written into the command queue when it is taken and passes from the queue head
//   into the output register once out_ch can take a new result; a closing '#' is
//   queued the same way and takes effect before any later tick. The slot sequencer
//   pops one queue entry per cycle; a tick entry waits while out_ch stalls.
// Reset and stalls:
//   reset clears the capture state, the queue and the sequencer and loads the default
//   widths (10, 2, 5, 8). When out_ch stalls, ticks collect in the queue
//   (QUEUE_DEPTH entries) and in_ch.ready drops once it is full.
module irig_b_time_code_encoder_top #(
  parameter int QUEUE_DEPTH = irig_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  irig_in_if.sink     in_ch,
  irig_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [7:0]  cfg_wdata
);

  irig_pkg::cfg_t    cfg_r, cfg_nxt;
  irig_pkg::cmd_t    push_cmd;
  irig_pkg::cmd_t    head;
  irig_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        irig_pkg::CFG_TICKS_PER_SLOT: cfg_nxt.ticks_per_slot = cfg_wdata;
        irig_pkg::CFG_ZERO_WIDTH:     cfg_nxt.zero_width     = cfg_wdata;
        irig_pkg::CFG_ONE_WIDTH:      cfg_nxt.one_width      = cfg_wdata;
        irig_pkg::CFG_MARKER_WIDTH:   cfg_nxt.marker_width   = cfg_wdata;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_slot <= irig_pkg::RST_TICKS_PER_SLOT;
      cfg_r.zero_width     <= irig_pkg::RST_ZERO_WIDTH;
      cfg_r.one_width      <= irig_pkg::RST_ONE_WIDTH;
      cfg_r.marker_width   <= irig_pkg::RST_MARKER_WIDTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  irig_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  irig_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  irig_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
